FILE: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ptcomp_pkg.sv
// Widths, constants and register codes for the pressure/temperature compensation block.
package ptcomp_pkg;

    localparam int RAW_W    = 24;
    localparam int COEFF_W  = 16;
    localparam int TEMP_W   = 19;
    localparam int PRES_W   = 32;
    localparam int IDX_W    = 3;
    localparam int N_COEFFS = 6;
    localparam int STAGES   = 8;

    localparam int S_TDATA_W = 48;  // raw_pressure, raw_temperature
    localparam int M_TDATA_W = 56;  // temperature_centi, pressure_centi, zero fill

    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

    typedef enum logic [IDX_W-1:0] {
        IDX_PRESS_SENS = 3'd0,
        IDX_PRESS_OFF  = 3'd1,
        IDX_SENS_TC    = 3'd2,
        IDX_OFF_TC     = 3'd3,
        IDX_TEMP_REF   = 3'd4,
        IDX_TEMP_SLOPE = 3'd5
    } coeff_idx_t;

endpackage

FILE: rtl/pressure_temperature_compensation.sv
// Compensation pipeline: raw pressure/temperature pair in, centi-unit results out.
//
// Usage:
//   s_ channel: one word per conversion pair, s_tdata = {raw_temperature, raw_pressure}
//   (raw_pressure in bits 23:0). m_ channel: one result word per input word,
//   m_tdata = {pad, pressure_centi, temperature_centi}, m_tuser = status.
//   cfg channel: cfg_index selects calibration word 0..5, cfg_data is the value;
//   indexes 6 and 7 are dropped. cfg_ready is always high; write only while idle.
// Timing:
//   8 register stages (input subtract, three coefficient multipliers and the dT square,
//   scaling, square of the temperature delta, second-order correction, split 24x37
//   pressure product, product recombine, offset subtract into the output register).
//   One word per cycle is sustained while m_tready is high.
// Stall:
//   Each stage advances when it is empty or the stage after it advances, so bubbles
//   collapse and s_tready drops only when all 8 stages hold words and m_tready is low.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and clears all six
//   calibration words to zero.
// A zero raw value gives zero temperature and pressure with status set.
module pressure_temperature_compensation (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // raw_pressure[23:0], raw_temperature[47:24]
    input  logic [ptcomp_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // temperature_centi[18:0], pressure_centi[50:19], zero[55:51]
    output logic [ptcomp_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[0]
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ptcomp_pkg::IDX_W-1:0]       cfg_index,
    input  logic [ptcomp_pkg::COEFF_W-1:0]     cfg_data
);

    localparam int NS = ptcomp_pkg::STAGES;

    // ---------------- calibration words ----------------
    logic [ptcomp_pkg::COEFF_W-1:0] coeff_reg [ptcomp_pkg::N_COEFFS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ptcomp_pkg::N_COEFFS; i++) begin
                coeff_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (ptcomp_pkg::coeff_idx_t'(cfg_index))
                ptcomp_pkg::IDX_PRESS_SENS: coeff_reg[ptcomp_pkg::IDX_PRESS_SENS] <= cfg_data;
                ptcomp_pkg::IDX_PRESS_OFF:  coeff_reg[ptcomp_pkg::IDX_PRESS_OFF]  <= cfg_data;
                ptcomp_pkg::IDX_SENS_TC:    coeff_reg[ptcomp_pkg::IDX_SENS_TC]    <= cfg_data;
                ptcomp_pkg::IDX_OFF_TC:     coeff_reg[ptcomp_pkg::IDX_OFF_TC]     <= cfg_data;
                ptcomp_pkg::IDX_TEMP_REF:   coeff_reg[ptcomp_pkg::IDX_TEMP_REF]   <= cfg_data;
                ptcomp_pkg::IDX_TEMP_SLOPE: coeff_reg[ptcomp_pkg::IDX_TEMP_SLOPE] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS:1]   vld_reg;
    logic [NS:1]   vld_next;
    logic [NS+1:1] adv;

    always_comb begin
        adv[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--) begin
            adv[k] = ~vld_reg[k] | adv[k+1];
        end
        vld_next[1] = adv[1] ? s_tvalid : vld_reg[1];
        for (int k = 2; k <= NS; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[NS];

    // ---------------- stage 1: dT, invalid flag ----------------
    logic [23:0]        in_d1;
    logic [23:0]        in_d2;
    logic signed [24:0] s1_dt_next;
    logic               s1_inv_next;
    logic signed [24:0] s1_dt_reg;
    logic [23:0]        s1_d1_reg;
    logic               s1_inv_reg;

    assign in_d1       = s_tdata[23:0];
    assign in_d2       = s_tdata[47:24];
    assign s1_dt_next  = $signed({1'b0, in_d2})
                       - $signed({1'b0, coeff_reg[ptcomp_pkg::IDX_TEMP_REF], 8'b0});
    assign s1_inv_next = (in_d1 == '0) || (in_d2 == '0);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_dt_reg  <= s1_dt_next;
            s1_d1_reg  <= in_d1;
            s1_inv_reg <= s1_inv_next;
        end
    end

    // ---------------- stage 2: coefficient products ----------------
    logic signed [40:0] s2_pt_next, s2_po_next, s2_ps_next;
    logic signed [49:0] s2_pdd_next;
    logic signed [40:0] s2_pt_reg, s2_po_reg, s2_ps_reg;
    logic [47:0]        s2_pdd_reg;
    logic [23:0]        s2_d1_reg;
    logic               s2_inv_reg;

    assign s2_pt_next  = s1_dt_reg * $signed({1'b0, coeff_reg[ptcomp_pkg::IDX_TEMP_SLOPE]});
    assign s2_po_next  = s1_dt_reg * $signed({1'b0, coeff_reg[ptcomp_pkg::IDX_OFF_TC]});
    assign s2_ps_next  = s1_dt_reg * $signed({1'b0, coeff_reg[ptcomp_pkg::IDX_SENS_TC]});
    assign s2_pdd_next = s1_dt_reg * s1_dt_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s2_pt_reg  <= s2_pt_next;
            s2_po_reg  <= s2_po_next;
            s2_ps_reg  <= s2_ps_next;
            s2_pdd_reg <= s2_pdd_next[47:0];   // square stays below 2^48
            s2_d1_reg  <= s1_d1_reg;
            s2_inv_reg <= s1_inv_reg;
        end
    end

    // ---------------- stage 3: first order terms ----------------
    logic signed [17:0] s3_td_next;
    logic signed [18:0] s3_temp_next;
    logic signed [35:0] s3_off_next;
    logic signed [34:0] s3_sens_next;
    logic [51:0]        s3_p11;
    logic signed [17:0] s3_td_reg;
    logic signed [18:0] s3_temp_reg;
    logic signed [35:0] s3_off_reg;
    logic signed [34:0] s3_sens_reg;
    logic [16:0]        s3_ti_reg;
    logic               s3_low_reg;
    logic [23:0]        s3_d1_reg;
    logic               s3_inv_reg;

    assign s3_td_next   = s2_pt_reg[40:23];
    assign s3_temp_next = ptcomp_pkg::TEMP_REF + $signed({s3_td_next[17], s3_td_next});
    assign s3_off_next  = $signed({3'b0, coeff_reg[ptcomp_pkg::IDX_PRESS_OFF], 17'b0})
                        + $signed({s2_po_reg[40], s2_po_reg[40:6]});
    assign s3_sens_next = $signed({3'b0, coeff_reg[ptcomp_pkg::IDX_PRESS_SENS], 16'b0})
                        + $signed({s2_ps_reg[40], s2_ps_reg[40:7]});
    // 11 * dT^2 as shift-add
    assign s3_p11 = {1'b0, s2_pdd_reg, 3'b0} + {3'b0, s2_pdd_reg, 1'b0} + {4'b0, s2_pdd_reg};

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s3_td_reg   <= s3_td_next;
            s3_temp_reg <= s3_temp_next;
            s3_off_reg  <= s3_off_next;
            s3_sens_reg <= s3_sens_next;
            s3_ti_reg   <= s3_p11[51:35];
            s3_low_reg  <= s3_td_next[17];     // TEMP below 20.00 C
            s3_d1_reg   <= s2_d1_reg;
            s3_inv_reg  <= s2_inv_reg;
        end
    end

    // ---------------- stage 4: (TEMP - 2000)^2 ----------------
    logic signed [35:0] s4_sq_next;
    logic [34:0]        s4_sq_reg;
    logic signed [18:0] s4_temp_reg;
    logic signed [35:0] s4_off_reg;
    logic signed [34:0] s4_sens_reg;
    logic [16:0]        s4_ti_reg;
    logic               s4_low_reg;
    logic [23:0]        s4_d1_reg;
    logic               s4_inv_reg;

    assign s4_sq_next = s3_td_reg * s3_td_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s4_sq_reg   <= s4_sq_next[34:0];
            s4_temp_reg <= s3_temp_reg;
            s4_off_reg  <= s3_off_reg;
            s4_sens_reg <= s3_sens_reg;
            s4_ti_reg   <= s3_ti_reg;
            s4_low_reg  <= s3_low_reg;
            s4_d1_reg   <= s3_d1_reg;
            s4_inv_reg  <= s3_inv_reg;
        end
    end

    // ---------------- stage 5: second order corrections ----------------
    logic [39:0]        s5_m31;
    logic [40:0]        s5_m63;
    logic [36:0]        s5_offi;
    logic [35:0]        s5_sensi;
    logic signed [37:0] s5_off_next;
    logic signed [36:0] s5_sens_next;
    logic signed [18:0] s5_temp_next;
    logic signed [37:0] s5_off_reg;
    logic signed [36:0] s5_sens_reg;
    logic signed [18:0] s5_temp_reg;
    logic [23:0]        s5_d1_reg;
    logic               s5_inv_reg;

    assign s5_m31   = {s4_sq_reg, 5'b0} - {5'b0, s4_sq_reg};
    assign s5_m63   = {s4_sq_reg, 6'b0} - {6'b0, s4_sq_reg};
    assign s5_offi  = s4_low_reg ? s5_m31[39:3] : '0;
    assign s5_sensi = s4_low_reg ? s5_m63[40:5] : '0;

    assign s5_off_next  = $signed({{2{s4_off_reg[35]}}, s4_off_reg}) - $signed({1'b0, s5_offi});
    assign s5_sens_next = $signed({{2{s4_sens_reg[34]}}, s4_sens_reg})
                        - $signed({1'b0, s5_sensi});
    assign s5_temp_next = s4_temp_reg
                        - $signed({2'b0, (s4_low_reg ? s4_ti_reg : 17'd0)});

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
            s5_temp_reg <= s5_temp_next;
            s5_d1_reg   <= s4_d1_reg;
            s5_inv_reg  <= s4_inv_reg;
        end
    end

    // ---------------- stage 6: D1 * SENS, split in two halves ----------------
    logic [42:0]        s6_plo_next;
    logic signed [42:0] s6_phi_next;
    logic [42:0]        s6_plo_reg;
    logic signed [42:0] s6_phi_reg;
    logic signed [37:0] s6_off_reg;
    logic signed [18:0] s6_temp_reg;
    logic               s6_inv_reg;

    assign s6_plo_next = {19'b0, s5_d1_reg} * {24'b0, s5_sens_reg[18:0]};
    assign s6_phi_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[36:19]);

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            s6_plo_reg  <= s6_plo_next;
            s6_phi_reg  <= s6_phi_next;
            s6_off_reg  <= s5_off_reg;
            s6_temp_reg <= s5_temp_reg;
            s6_inv_reg  <= s5_inv_reg;
        end
    end

    // ---------------- stage 7: recombine product ----------------
    logic signed [61:0] s7_prod_next;
    logic signed [61:0] s7_prod_reg;
    logic signed [37:0] s7_off_reg;
    logic signed [18:0] s7_temp_reg;
    logic               s7_inv_reg;

    assign s7_prod_next = $signed({s6_phi_reg, 19'b0}) + $signed({19'b0, s6_plo_reg});

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            s7_prod_reg <= s7_prod_next;
            s7_off_reg  <= s6_off_reg;
            s7_temp_reg <= s6_temp_reg;
            s7_inv_reg  <= s6_inv_reg;
        end
    end

    // ---------------- stage 8: pressure, output word ----------------
    logic signed [40:0] s8_a;
    logic signed [43:0] s8_q;
    logic signed [43:0] s8_sh;
    logic signed [18:0] out_temp_reg;
    logic [31:0]        out_pres_reg;
    logic               out_status_reg;

    assign s8_a  = s7_prod_reg[61:21];
    assign s8_q  = $signed({{3{s8_a[40]}}, s8_a}) - $signed({{6{s7_off_reg[37]}}, s7_off_reg});
    assign s8_sh = s8_q >>> 15;

    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            out_temp_reg   <= s7_inv_reg ? '0 : s7_temp_reg;
            out_pres_reg   <= s7_inv_reg ? '0 : s8_sh[31:0];
            out_status_reg <= s7_inv_reg;
        end
    end

    assign m_tdata = {5'b0, out_pres_reg, out_temp_reg};
    assign m_tuser = out_status_reg;

    // ---------------- checks ----------------
    logic                           chk_inv_out;
    logic                           chk_full;
    logic                           chk_ref_wr;
    logic [ptcomp_pkg::COEFF_W-1:0] chk_ref_coeff;

    assign chk_inv_out   = m_tvalid && m_tuser;
    assign chk_full      = (&vld_reg) && !m_tready;
    assign chk_ref_wr    = cfg_valid && (cfg_index == ptcomp_pkg::IDX_TEMP_REF);
    assign chk_ref_coeff = coeff_reg[ptcomp_pkg::IDX_TEMP_REF];

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_invalid_zero, aclk, aresetn, chk_inv_out, m_tdata == '0, "bad invalid word")
    `ASSERT_IMPLIES(a_stall_full, aclk, aresetn, !s_tready, chk_full, "stall with a bubble")
    `ASSERT_NEXT(a_cfg_ref, aclk, aresetn, chk_ref_wr, chk_ref_coeff == $past(cfg_data), "write lost")

endmodule
